// ----- rtl/gradient_noise_unit_core_macros.svh -----
// ----------------------------------------------------------------------------
// gradient_noise_unit_core_macros.svh
// Assertion macros for the gradient noise core. Empty bodies under SYNTH.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_UNIT_CORE_MACROS_SVH
`define GRADIENT_NOISE_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define GNU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GNU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GNU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define GNU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/gnu_pkg.sv -----
// ----------------------------------------------------------------------------
// gnu_pkg
// Types, constants and gradient helpers shared by the gradient noise core.
// ----------------------------------------------------------------------------
`default_nettype none
package gnu_pkg;
  localparam int FRAC    = 16;             // fraction bits of coordinates/results
  localparam int MAX_OCT = 16;             // octave limit in fractal mode
  localparam int TBL_AW  = 8;              // permutation store address bits
  localparam int OCT_W   = 5;
  localparam int OUT_W   = 24;
  localparam int Q_W     = FRAC + 2;       // fraction, fade value, t operand
  localparam int W_W     = FRAC + 8;       // gradients, lerp terms, fade temps
  localparam int P_W     = Q_W + W_W;      // full product
  localparam int ACC_W   = W_W + MAX_OCT + 6;

  // stream packing
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 24;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [W_W-1:0]   w_t;
  typedef logic signed [P_W-1:0]   p_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [TBL_AW-1:0]       idx_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_N3    = 2'd1,
    OP_N2    = 2'd2,
    OP_FRACT = 2'd3
  } op_t;

  localparam q_t   ONE_Q   = q_t'(64'(1) << FRAC);
  localparam w_t   FADE15  = w_t'(64'(15) << FRAC);
  localparam w_t   FADE10  = w_t'(64'(10) << FRAC);
  localparam acc_t OUT_MAX = acc_t'((64'(1) << (OUT_W - 1)) - 64'(1));
  localparam acc_t OUT_MIN = -OUT_MAX - acc_t'(1);

  // gradient of one corner; 2D uses only the two sign bits
  function automatic w_t grad_val(input logic is3d, input logic [3:0] h,
                                  input q_t x, input q_t y, input q_t z);
    q_t u;
    q_t v;
    w_t su;
    w_t sv;
    u = (!is3d || h < 4'd8) ? x : y;
    if (!is3d || h < 4'd4) v = y;
    else if (h inside {4'd12, 4'd14}) v = x;
    else v = z;
    su = h[0] ? -w_t'(u) : w_t'(u);
    sv = h[1] ? -w_t'(v) : w_t'(v);
    return su + sv;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input acc_t v);
    if (v > OUT_MAX) return OUT_MAX[OUT_W-1:0];
    if (v < OUT_MIN) return OUT_MIN[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/gradient_noise_unit_core.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_unit_core
// Improved Perlin noise (3D, 2D, fractal 2D) over a loadable permutation RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* carries one item per handshake; tuser is the operation. A load item
//    writes one permutation entry in the accept cycle and returns nothing.
//    Load all 256 entries before asking for noise.
//  - m_* returns one noise value per noise item, signed Q.16, saturated.
//  - One item at a time: s_tready is high only while idle. The item time
//    is set by the single-port permutation RAM (one read per cycle, 14
//    reads for 3D) and the one shared multiplier, which runs the three
//    fade curves interleaved during the reads and then the dependent
//    lerp chain, one multiply state and one add state per lerp. A fractal
//    item with zero octaves goes straight to the result.
//  - The result sits in an output register; while the receiver stalls the
//    core may accept and work the next item and waits only to hand it over.
//  - Reset (rst, synchronous) clears control state; the permutation RAM is
//    not cleared and holds whatever was last loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gradient_noise_unit_core_macros.svh"
module gradient_noise_unit_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z, [100:96] octave_count,
  // [108:101] table_index, [116:109] table_value, [119:117] zero
  input  logic [gnu_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] operation
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [23:0] noise_value
  output logic [gnu_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import gnu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RDG, ST_LWAIT, ST_LMUL, ST_LADD, ST_OCT, ST_FIN
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] ch;
    logic [1:0] stg;
  } fade_tag_t;

  // input fields
  logic [31:0]      in_x, in_y, in_z;
  logic [OCT_W-1:0] in_oct;
  idx_t             in_idx, in_val;
  op_t              in_op;

  assign in_x   = s_tdata[31:0];
  assign in_y   = s_tdata[63:32];
  assign in_z   = s_tdata[95:64];
  assign in_oct = s_tdata[100:96];
  assign in_idx = s_tdata[108:101];
  assign in_val = s_tdata[116:109];
  assign in_op  = op_t'(s_tuser);

  state_t           state;
  op_t              op;
  logic [31:0]      cx, cy, cz;
  logic [OCT_W-1:0] oct_n, oi;
  logic [3:0]       rcnt;
  idx_t             a_r, b_r;
  idx_t             s [4];          // corner hash bases
  w_t               q [8];          // lerp operand queue
  logic [3:0]       qn;
  logic [2:0]       lj;
  w_t               f [3];          // fade curves u, v, w
  logic             fade_run, fade_done;
  logic [1:0]       fch, fstg;
  fade_tag_t        ftag;
  acc_t             acc;

  // permutation RAM
  idx_t perm_mem [256];
  idx_t rd_data;
  idx_t raddr;
  logic load_we;

  assign s_tready = (state == ST_IDLE);
  assign load_we  = s_tvalid && s_tready && (in_op == OP_LOAD);

  always_ff @(posedge clk) begin
    if (load_we) perm_mem[in_idx] <= in_val;
    else         rd_data <= perm_mem[raddr];
  end

  // cell coordinates and fractions
  idx_t xi, yi, zi;
  q_t   x0, y0, z0, x1, y1, z1;
  logic is3d;

  assign xi   = cx[FRAC +: TBL_AW];
  assign yi   = cy[FRAC +: TBL_AW];
  assign zi   = cz[FRAC +: TBL_AW];
  assign x0   = q_t'(cx[FRAC-1:0]);
  assign y0   = q_t'(cy[FRAC-1:0]);
  assign z0   = q_t'(cz[FRAC-1:0]);
  assign x1   = x0 - ONE_Q;
  assign y1   = y0 - ONE_Q;
  assign z1   = z0 - ONE_Q;
  assign is3d = (op == OP_N3);

  // read addresses: hash chain, then one read per corner
  always_comb begin
    case (state)
      ST_RD0:  raddr = xi + idx_t'(rcnt[0]);
      ST_RD1:  raddr = (rcnt[1] ? b_r : a_r) + idx_t'(rcnt[0]);
      ST_RDG:  raddr = is3d ? s[rcnt[1:0]] + idx_t'(rcnt[2])
                            : s[{1'b0, rcnt[0]}] + idx_t'(rcnt[1]);
      default: raddr = xi;
    endcase
  end

  // data captured at rcnt belongs to the read issued at rcnt-1
  logic [2:0] cslot;
  logic [3:0] ng;
  w_t         grad;
  assign cslot = 3'(rcnt - 4'd1);
  assign ng    = is3d ? 4'd8 : 4'd4;
  assign grad  = grad_val(is3d, rd_data[3:0],
                          cslot[0] ? x1 : x0,
                          cslot[1] ? y1 : y0,
                          cslot[2] ? z1 : z0);

  // shared multiplier: fades while reading, lerps afterwards
  q_t ft, lt, mul_t;
  w_t fb, mul_d, mul_q, lerp_res;
  logic [1:0] lsel;

  always_comb begin
    case (fch)
      2'd0:    ft = x0;
      2'd1:    ft = y0;
      default: ft = z0;
    endcase
    fb = (fstg == 2'd0) ? (w_t'(ft) <<< 2) + (w_t'(ft) <<< 1) - FADE15 : f[fch];
    if (is3d) lsel = (lj < 3'd4) ? 2'd0 : ((lj < 3'd6) ? 2'd1 : 2'd2);
    else      lsel = (lj < 3'd2) ? 2'd0 : 2'd1;
    lt    = q_t'(f[lsel][Q_W-1:0]);
    mul_t = (state == ST_LMUL) ? lt : ft;
    mul_d = (state == ST_LMUL) ? q[1] - q[0] : fb;
  end

  gnu_mulq u_mulq (
    .clk   (clk),
    .mul_t (mul_t),
    .mul_d (mul_d),
    .mul_q (mul_q)
  );

  assign lerp_res = q[0] + mul_q;

  logic [2:0]       wpos;
  logic [OCT_W-1:0] shamt;
  assign wpos  = 3'(qn - 4'd2);
  assign shamt = OCT_W'(MAX_OCT) - oi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      fade_run  <= 1'b0;
      fade_done <= 1'b0;
      ftag      <= '0;
      fch       <= '0;
      fstg      <= '0;
      rcnt      <= '0;
      qn        <= '0;
      lj        <= '0;
    end else begin
      // a handover in ST_FIN refills the output register instead
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;

      // fade sequencer: channels x, y, z interleaved, four products each
      ftag <= '{valid: fade_run, ch: fch, stg: fstg};
      if (fade_run) begin
        if (fch == 2'd2) begin
          fch <= 2'd0;
          if (fstg == 2'd3) fade_run <= 1'b0;
          else              fstg <= fstg + 2'd1;
        end else begin
          fch <= fch + 2'd1;
        end
      end
      if (ftag.valid) begin
        f[ftag.ch] <= (ftag.stg == 2'd0) ? mul_q + FADE10 : mul_q;
        if (ftag.ch == 2'd2 && ftag.stg == 2'd3) fade_done <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid && in_op != OP_LOAD) begin
            op    <= in_op;
            cx    <= in_x;
            cy    <= in_y;
            cz    <= in_z;
            oct_n <= (in_oct > OCT_W'(MAX_OCT)) ? OCT_W'(MAX_OCT) : in_oct;
            oi    <= '0;
            acc   <= '0;
            if (in_op == OP_FRACT && in_oct == '0) begin
              state <= ST_FIN;
            end else begin
              state     <= ST_RD0;
              rcnt      <= '0;
              fade_run  <= 1'b1;
              fch       <= '0;
              fstg      <= '0;
              fade_done <= 1'b0;
            end
          end
        end
        ST_RD0: begin
          if (rcnt == 4'd1) begin
            a_r  <= rd_data + yi;
            s[0] <= rd_data + yi;
          end
          if (rcnt == 4'd2) begin
            b_r   <= rd_data + yi;
            s[1]  <= rd_data + yi;
            rcnt  <= '0;
            state <= is3d ? ST_RD1 : ST_RDG;
          end else begin
            rcnt <= rcnt + 4'd1;
          end
        end
        ST_RD1: begin
          if (rcnt != 4'd0) s[{cslot[0], cslot[1]}] <= rd_data + zi;
          if (rcnt == 4'd4) begin
            rcnt  <= '0;
            state <= ST_RDG;
          end else begin
            rcnt <= rcnt + 4'd1;
          end
        end
        ST_RDG: begin
          if (rcnt != 4'd0) q[cslot] <= grad;
          if (rcnt == ng) begin
            rcnt  <= '0;
            qn    <= ng;
            lj    <= '0;
            state <= ST_LWAIT;
          end else begin
            rcnt <= rcnt + 4'd1;
          end
        end
        ST_LWAIT: begin
          if (fade_done) state <= ST_LMUL;
        end
        ST_LMUL: begin
          state <= ST_LADD;
        end
        ST_LADD: begin
          // pop the pair, append its lerp at the tail
          for (int i = 0; i < 8; i++) begin
            if (3'(i) == wpos)  q[i] <= lerp_res;
            else if (i < 6)     q[i] <= q[i+2];
          end
          qn <= qn - 4'd1;
          // 2D skips the second tier: its third lerp is the final one
          lj <= (!is3d && lj == 3'd1) ? 3'd6 : lj + 3'd1;
          if (qn == 4'd2) begin
            if (op == OP_FRACT) begin
              acc   <= acc + (acc_t'(lerp_res) <<< shamt);
              state <= ST_OCT;
            end else begin
              acc   <= acc_t'(lerp_res);
              state <= ST_FIN;
            end
          end else begin
            state <= ST_LMUL;
          end
        end
        ST_OCT: begin
          oi <= oi + 1'b1;
          cx <= cx << 1;
          cy <= cy << 1;
          if (oi + 1'b1 < oct_n) begin
            state     <= ST_RD0;
            rcnt      <= '0;
            fade_run  <= 1'b1;
            fch       <= '0;
            fstg      <= '0;
            fade_done <= 1'b0;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sat_out((op == OP_FRACT) ? (acc >>> (MAX_OCT - 1)) : acc);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GNU_ASSERT_IMP(a_lerp_after_fade, clk, rst, state == ST_LMUL, fade_done, "lerp before fade ready")
  `GNU_ASSERT_IMP(a_queue_depth, clk, rst, state == ST_LMUL, qn >= 4'd2 && qn <= 4'd8, "lerp queue depth")
  `GNU_ASSERT_NXT(a_fin_hands_over, clk, rst, state == ST_FIN && (!m_tvalid || m_tready), m_tvalid && state == ST_IDLE, "result not delivered")
endmodule
`default_nettype wire

// ----- rtl/gnu_mulq.sv -----
// ----------------------------------------------------------------------------
// gnu_mulq
// Shared fixed-point multiplier: registered product, floor shift by FRAC.
// ----------------------------------------------------------------------------
`default_nettype none
module gnu_mulq (
  input  logic        clk,
  input  gnu_pkg::q_t mul_t,
  input  gnu_pkg::w_t mul_d,
  output gnu_pkg::w_t mul_q
);
  import gnu_pkg::*;

  p_t prod;

  always_ff @(posedge clk) begin
    prod <= p_t'(mul_t) * p_t'(mul_d);
  end

  // arithmetic shift rounds toward minus infinity
  assign mul_q = w_t'(prod >>> FRAC);
endmodule
`default_nettype wire

// ----- tb/sv/tb_gradient_noise_unit_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_unit_core
// Self-checking bench for the gradient noise core: loads the permutation
// store, then runs directed and random 3D, 2D and fractal items under random
// sender bursts and receiver stalls, comparing each result with a predictor.
// ----------------------------------------------------------------------------
module tb_gradient_noise_unit_core;
  import gnu_pkg::*;

  localparam longint ONE = 64'sd1 <<< 16;

  typedef struct {
    op_t        op;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [4:0]  oct;
    logic [7:0]  idx;
    logic [7:0]  val;
  } noise_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = OP_LOAD;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  noise_item_t     pending_q[$];
  logic [23:0]     noise_expect_q[$];
  logic [7:0]      perm_tbl [256];
  int              errors = 0;
  int              sent_cnt = 0;
  int              checked_cnt = 0;
  int              hold_at = -1;     // sender waits for drain at this count
  int              gap_left = 0;
  int              burst_left = 4;
  int              rx_cyc = 0;

  gradient_noise_unit_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint mul_fx(longint a, longint b);
    return (a * b) >>> 16;           // floor rounding
  endfunction

  function automatic longint fade_fx(longint t);
    longint b;
    b = mul_fx(t, 6 * t - 15 * ONE) + 10 * ONE;
    return mul_fx(t, mul_fx(t, mul_fx(t, b)));
  endfunction

  function automatic longint lerp_fx(longint t, longint a, longint b);
    return a + mul_fx(t, b - a);
  endfunction

  function automatic longint pv(int unsigned i);
    return longint'(perm_tbl[i & 255]);
  endfunction

  function automatic longint grad3_fx(longint h_in, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = h_in[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint grad2_fx(longint h, longint x, longint y);
    return (h[0] ? -x : x) + (h[1] ? -y : y);
  endfunction

  function automatic longint noise2_fx(logic [31:0] cx, logic [31:0] cy);
    int unsigned xi, yi, a, b;
    longint x, y, u, v, l0, l1;
    xi = cx[23:16]; yi = cy[23:16];
    x = cx[15:0];   y = cy[15:0];
    u = fade_fx(x); v = fade_fx(y);
    a = (pv(xi) + yi) & 255;
    b = (pv(xi + 1) + yi) & 255;
    l0 = lerp_fx(u, grad2_fx(pv(a), x, y), grad2_fx(pv(b), x - ONE, y));
    l1 = lerp_fx(u, grad2_fx(pv(a + 1), x, y - ONE),
                 grad2_fx(pv(b + 1), x - ONE, y - ONE));
    return lerp_fx(v, l0, l1);
  endfunction

  function automatic longint noise3_fx(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    int unsigned xi, yi, zi, a, aa, ab, b, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, n0, n1;
    xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
    x = cx[15:0]; y = cy[15:0]; z = cz[15:0];
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    u = fade_fx(x); v = fade_fx(y); w = fade_fx(z);
    a  = (pv(xi) + yi) & 255;
    aa = (pv(a) + zi) & 255;
    ab = (pv(a + 1) + zi) & 255;
    b  = (pv(xi + 1) + yi) & 255;
    ba = (pv(b) + zi) & 255;
    bb = (pv(b + 1) + zi) & 255;
    n0 = lerp_fx(v,
      lerp_fx(u, grad3_fx(pv(aa), x, y, z), grad3_fx(pv(ba), x1, y, z)),
      lerp_fx(u, grad3_fx(pv(ab), x, y1, z), grad3_fx(pv(bb), x1, y1, z)));
    n1 = lerp_fx(v,
      lerp_fx(u, grad3_fx(pv(aa + 1), x, y, z1), grad3_fx(pv(ba + 1), x1, y, z1)),
      lerp_fx(u, grad3_fx(pv(ab + 1), x, y1, z1), grad3_fx(pv(bb + 1), x1, y1, z1)));
    return lerp_fx(w, n0, n1);
  endfunction

  function automatic longint fractal_fx(logic [31:0] cx, logic [31:0] cy, int unsigned oct);
    longint acc;
    acc = 0;
    if (oct > MAX_OCT) oct = MAX_OCT;
    for (int i = 0; i < oct; i++) begin
      acc += noise2_fx(cx, cy) * (64'sd1 <<< (MAX_OCT - i));
      cx = cx << 1;
      cy = cy << 1;
    end
    return acc >>> (MAX_OCT - 1);
  endfunction

  // applies one accepted item to the shadow store / expected results
  task automatic predict_noise(noise_item_t it);
    longint r;
    if (it.op == OP_LOAD) begin
      perm_tbl[it.idx] = it.val;
    end else begin
      if (it.op == OP_N3) r = noise3_fx(it.cx, it.cy, it.cz);
      else if (it.op == OP_N2) r = noise2_fx(it.cx, it.cy);
      else r = fractal_fx(it.cx, it.cy, it.oct);
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      noise_expect_q.push_back(r[23:0]);
    end
  endtask

  function automatic noise_item_t mk_item(op_t op, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [4:0] oct);
    noise_item_t it;
    it.op = op; it.cx = x; it.cy = y; it.cz = z; it.oct = oct;
    it.idx = 8'($urandom); it.val = 8'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000; // near origin
      1: return {16'($urandom_range(0, 65535)), 16'h0000};        // whole cell
      default: return $urandom;
    endcase
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        noise_item_t acc_it;
        acc_it.op  = op_t'(s_tuser);
        acc_it.cx  = s_tdata[31:0];
        acc_it.cy  = s_tdata[63:32];
        acc_it.cz  = s_tdata[95:64];
        acc_it.oct = s_tdata[100:96];
        acc_it.idx = s_tdata[108:101];
        acc_it.val = s_tdata[116:109];
        predict_noise(acc_it);
      end
      if (sent_cnt == hold_at && noise_expect_q.size() == 0) hold_at = -1;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sent_cnt == hold_at || pending_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        noise_item_t it;
        it = pending_q.pop_front();
        s_tuser  <= it.op;
        s_tdata  <= {3'b000, it.val, it.idx, it.oct, it.cz, it.cy, it.cx};
        s_tvalid <= 1'b1;
        sent_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (!rst) begin
      rx_cyc++;
      if (m_tvalid && m_tready) begin
        if (noise_expect_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_tdata);
          errors++;
        end else begin
          logic [23:0] exp_v;
          exp_v = noise_expect_q.pop_front();
          checked_cnt++;
          if (m_tdata !== exp_v) begin
            $display("%0t: noise_value mismatch, expected %h actual %h",
                     $time, exp_v, m_tdata);
            errors++;
          end
        end
      end
      // stall pattern cycles through free-running, light and heavy phases
      case ((rx_cyc / 1500) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    logic [7:0] shuf [256];
    int         n_rand;
    op_t        rop;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill every permutation entry with a shuffled byte sequence
    for (int i = 0; i < 256; i++) shuf[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      int j;
      logic [7:0] t;
      j = $urandom_range(0, i);
      t = shuf[i]; shuf[i] = shuf[j]; shuf[j] = t;
    end
    for (int i = 0; i < 256; i++) begin
      noise_item_t it;
      it = mk_item(OP_LOAD, $urandom, $urandom, $urandom, 5'($urandom));
      it.idx = 8'(i); it.val = shuf[i];
      pending_q.push_back(it);
    end

    // directed: corners of the coordinate range, cell edges, octave limits
    pending_q.push_back(mk_item(OP_N3, 0, 0, 0, 0));
    pending_q.push_back(mk_item(OP_N3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_q.push_back(mk_item(OP_N3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    pending_q.push_back(mk_item(OP_N3, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0001_8000, 0));
    pending_q.push_back(mk_item(OP_N3, 32'h0003_0000, 32'hFFFE_0000, 32'h00FF_0000, 0));
    pending_q.push_back(mk_item(OP_N3, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 31));
    pending_q.push_back(mk_item(OP_N2, 0, 0, 32'hFFFF_FFFF, 0));
    pending_q.push_back(mk_item(OP_N2, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_q.push_back(mk_item(OP_N2, 32'hFFFF_FFFF, 32'h0000_FFFF, 0, 0));
    pending_q.push_back(mk_item(OP_N2, 32'h0000_8000, 32'h00FF_4000, 0, 0));
    pending_q.push_back(mk_item(OP_FRACT, 32'h0001_2345, 32'h0004_5678, 0, 0));
    pending_q.push_back(mk_item(OP_FRACT, 32'h0001_2345, 32'h0004_5678, 0, 1));
    pending_q.push_back(mk_item(OP_FRACT, 32'h0000_8000, 32'h0000_4000, 0, 16));
    pending_q.push_back(mk_item(OP_FRACT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 17));
    pending_q.push_back(mk_item(OP_FRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 31));
    pending_q.push_back(mk_item(OP_FRACT, 32'h0000_C000, 32'h0000_C000, 0, 5));
    pending_q.push_back(mk_item(OP_LOAD, 0, 0, 0, 0));    // rewrite an entry
    pending_q.push_back(mk_item(OP_N2, 32'h0000_4000, 32'h0000_C000, 0, 0));
    hold_at = pending_q.size();    // drain fully before random traffic

    // random: mostly noise, some reloads; octaves kept small most of the time
    n_rand = 1950 - 256 - 18;
    for (int k = 0; k < n_rand; k++) begin
      logic [4:0] oct;
      case ($urandom_range(0, 9))
        0: rop = OP_LOAD;
        1, 2, 3: rop = OP_N3;
        4, 5, 6: rop = OP_N2;
        default: rop = OP_FRACT;
      endcase
      oct = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(0, 5));
      pending_q.push_back(mk_item(rop, rnd_coord(), rnd_coord(), rnd_coord(), oct));
    end

    wait (pending_q.size() == 0 && !s_tvalid && noise_expect_q.size() == 0);
    repeat (500) @(posedge clk);
    $display("Run covered %0d items (256 table loads first), %0d noise results checked,",
             sent_cnt, checked_cnt);
    $display("3D/2D/fractal mixes with sender gaps and receiver stalls.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gnu_pkg.sv
rtl/gnu_mulq.sv
rtl/gradient_noise_unit_core.sv
tb/sv/tb_gradient_noise_unit_core.sv
